// ===== hdl/xep_pkg.sv =====
// xep_pkg: shared types and constants for the xorshift entropy pool
// holds item kinds, register indexes, datapath op codes and the
// controller/datapath command and status structs; no dependencies
`timescale 1ns / 1ps

package xep_pkg;

    localparam int EST_W    = 13;
    localparam int ROUNDS_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 7'd16;
    localparam logic [EST_W-1:0]    CAP_RESET    = 13'd4096;

    // largest byte count debited by one extract
    localparam logic [2:0] MAX_BYTES = 3'd4;

    // item kinds as carried in s_tuser
    typedef enum logic [1:0] {
        KIND_MIX     = 2'd0,
        KIND_CREDIT  = 2'd1,
        KIND_EXTRACT = 2'd2,
        KIND_SEED    = 2'd3
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROUNDS = 2'd0,
        CFG_CAP    = 2'd1
    } cfg_idx_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP       = 4'd0,
        DP_CLEAR     = 4'd1,
        DP_LOAD      = 4'd2,
        DP_ADDR_DEC  = 4'd3,
        DP_ADDR_INC  = 4'd4,
        DP_HOLD_INC  = 4'd5,
        DP_ACC_RD    = 4'd6,
        DP_EXT_MIX   = 4'd7,
        DP_EXT_WR    = 4'd8,
        DP_MIX_WR    = 4'd9,
        DP_RND_WR    = 4'd10,
        DP_CREDIT    = 4'd11,
        DP_SEED_INIT = 4'd12,
        DP_SEED_WR   = 4'd13,
        DP_RESP      = 4'd14
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  last;
        logic  bytes_zero;
        logic  rounds_zero;
        logic  rounds_done;
        logic  addr_last;
    } dp_stat_t;

endpackage

// ===== hdl/xep_ctrl.sv =====
// xep_ctrl: sequencer for the entropy pool, one item at a time
// depends on xep_pkg; drives datapath commands and the stream handshakes
`timescale 1ns / 1ps

module xep_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    input  xep_pkg::dp_stat_t stat,
    output xep_pkg::dp_cmd_t  cmd
);
    import xep_pkg::*;

    typedef enum logic [12:0] {
        ST_CLEAR    = 13'b0000000000001,
        ST_IDLE     = 13'b0000000000010,
        ST_DISPATCH = 13'b0000000000100,
        ST_MIX_WR   = 13'b0000000001000,
        ST_RND_RD   = 13'b0000000010000,
        ST_RND_WR   = 13'b0000000100000,
        ST_EXT_RD0  = 13'b0000001000000,
        ST_EXT_RD1  = 13'b0000010000000,
        ST_EXT_RD2  = 13'b0000100000000,
        ST_EXT_MIX  = 13'b0001000000000,
        ST_EXT_WR   = 13'b0010000000000,
        ST_SEED     = 13'b0100000000000,
        ST_RESP     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

    // next state and command
    always_comb begin
        state_next     = state_reg;
        cmd.op         = DP_NOP;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = DP_CLEAR;
                if (stat.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (stat.kind)
                    KIND_MIX: begin
                        state_next = ST_MIX_WR;
                    end
                    KIND_CREDIT: begin
                        cmd.op     = DP_CREDIT;
                        state_next = ST_RESP;
                    end
                    KIND_EXTRACT: begin
                        if (stat.bytes_zero) begin
                            state_next = ST_RESP;
                        end else begin
                            cmd.op     = DP_ADDR_DEC;
                            state_next = ST_EXT_RD0;
                        end
                    end
                    KIND_SEED: begin
                        cmd.op     = DP_SEED_INIT;
                        state_next = ST_SEED;
                    end
                endcase
            end
            ST_MIX_WR: begin
                cmd.op = DP_MIX_WR;
                if (stat.last && !stat.rounds_zero) begin
                    state_next = ST_RND_RD;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RND_RD: begin
                state_next = ST_RND_WR;
            end
            ST_RND_WR: begin
                cmd.op = DP_RND_WR;
                if (stat.rounds_done) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_RND_RD;
                end
            end
            ST_EXT_RD0: begin
                cmd.op     = DP_ADDR_INC;
                state_next = ST_EXT_RD1;
            end
            ST_EXT_RD1: begin
                cmd.op     = DP_HOLD_INC;
                state_next = ST_EXT_RD2;
            end
            ST_EXT_RD2: begin
                cmd.op     = DP_ACC_RD;
                state_next = ST_EXT_MIX;
            end
            ST_EXT_MIX: begin
                cmd.op     = DP_EXT_MIX;
                state_next = ST_EXT_WR;
            end
            ST_EXT_WR: begin
                cmd.op     = DP_EXT_WR;
                state_next = ST_RESP;
            end
            ST_SEED: begin
                cmd.op = DP_SEED_WR;
                if (stat.addr_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // load the output register once it is free
                if (!out_valid_reg || m_ready) begin
                    cmd.op         = DP_RESP;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/xep_datapath.sv =====
// xep_datapath: pool memory, position, estimate, config and mixing logic
// depends on xep_pkg; executes one command from xep_ctrl per cycle
`timescale 1ns / 1ps

module xep_datapath #(
    parameter int POOL_DEPTH = 128
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  xep_pkg::dp_cmd_t                      cmd,
    output xep_pkg::dp_stat_t                     stat,
    input  xep_pkg::kind_t                        in_kind,
    input  logic [63:0]                           in_word,
    input  logic                                  in_last,
    input  logic [2:0]                            in_bytes,
    input  logic                                  cfg_we,
    input  logic [xep_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [xep_pkg::EST_W-1:0]             cfg_data,
    output logic [31:0]                           res_word,
    output logic                                  res_valid,
    output logic [xep_pkg::EST_W-1:0]             res_est
);
    import xep_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(POOL_DEPTH - 1);

    function automatic logic [31:0] xs_mix(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        x = a ^ b;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    logic [31:0] pool_mem [POOL_DEPTH];

    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [EST_W-1:0]    est_reg, est_next;
    logic [ROUNDS_W-1:0] rounds_reg, rounds_next;
    logic [EST_W-1:0]    cap_reg, cap_next;
    logic [ROUNDS_W-1:0] rcnt_reg, rcnt_next;
    logic                ext_ok_reg, ext_ok_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         hold_reg, hold_next;
    logic [31:0]         rd_reg;
    kind_t               kind_reg, kind_next;
    logic [63:0]         word_reg, word_next;
    logic                last_reg, last_next;
    logic [2:0]          bytes_reg, bytes_next;
    logic [31:0]         res_word_reg, res_word_next;
    logic                res_valid_reg, res_valid_next;
    logic [EST_W-1:0]    res_est_reg, res_est_next;

    logic                mem_we;
    logic [31:0]         mem_wdata;
    logic [AW-1:0]       addr_inc, addr_dec;
    logic [31:0]         mix_val, rnd_val, ext_val;
    logic                cap_hit;
    logic [EST_W-1:0]    credit_est, debit_est;
    logic [2:0]          bytes_eff;
    logic [5:0]          debit;

    // wrapping pool addresses
    assign addr_inc = (addr_reg == LAST_ADDR) ? '0 : addr_reg + AW'(1);
    assign addr_dec = (addr_reg == '0) ? LAST_ADDR : addr_reg - AW'(1);

    // mixing functions on registered read data
    assign mix_val = xs_mix(rd_reg, word_reg[31:0]);
    assign rnd_val = xs_mix(rd_reg, hold_reg);
    assign ext_val = xs_mix(xs_mix(acc_reg, rd_reg), hold_reg) ^ word_reg[31:0];

    // credit with saturation at the cap
    assign cap_hit = (|word_reg[63:EST_W]) || (word_reg[EST_W-1:0] >= cap_reg)
        || (({1'b0, est_reg} + {1'b0, word_reg[EST_W-1:0]}) > {1'b0, cap_reg});
    assign credit_est = cap_hit ? cap_reg : est_reg + word_reg[EST_W-1:0];

    // debit of eight bits per byte, floor at zero
    assign bytes_eff = (bytes_reg > MAX_BYTES) ? MAX_BYTES : bytes_reg;
    assign debit     = {bytes_eff, 3'b000};
    assign debit_est = (est_reg > {{(EST_W-6){1'b0}}, debit})
        ? est_reg - {{(EST_W-6){1'b0}}, debit} : '0;

    // status back to the controller
    assign stat.kind        = kind_reg;
    assign stat.last        = last_reg;
    assign stat.bytes_zero  = (bytes_reg == 3'd0);
    assign stat.rounds_zero = (rounds_reg == '0);
    assign stat.rounds_done = (({1'b0, rcnt_reg} + 8'd1) == {1'b0, rounds_reg});
    assign stat.addr_last   = (addr_reg == LAST_ADDR);

    assign res_word  = res_word_reg;
    assign res_valid = res_valid_reg;
    assign res_est   = res_est_reg;

    // command decode
    always_comb begin
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        est_next       = est_reg;
        rounds_next    = rounds_reg;
        cap_next       = cap_reg;
        rcnt_next      = rcnt_reg;
        ext_ok_next    = ext_ok_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        kind_next      = kind_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        bytes_next     = bytes_reg;
        res_word_next  = res_word_reg;
        res_valid_next = res_valid_reg;
        res_est_next   = res_est_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        unique case (cmd.op)
            DP_NOP: begin
            end
            DP_CLEAR: begin
                mem_we    = 1'b1;
                addr_next = addr_inc;
            end
            DP_LOAD: begin
                kind_next   = in_kind;
                word_next   = in_word;
                last_next   = in_last;
                bytes_next  = in_bytes;
                addr_next   = pos_reg;
                ext_ok_next = 1'b0;
            end
            DP_ADDR_DEC: begin
                addr_next = addr_dec;
            end
            DP_ADDR_INC: begin
                addr_next = addr_inc;
            end
            DP_HOLD_INC: begin
                hold_next = rd_reg;
                addr_next = addr_inc;
            end
            DP_ACC_RD: begin
                acc_next = rd_reg;
            end
            DP_EXT_MIX: begin
                acc_next  = ext_val;
                hold_next = rd_reg;
            end
            DP_EXT_WR: begin
                mem_we      = 1'b1;
                mem_wdata   = xs_mix(hold_reg, acc_reg);
                pos_next    = addr_reg;
                est_next    = debit_est;
                ext_ok_next = 1'b1;
            end
            DP_MIX_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mix_val;
                hold_next = mix_val;
                addr_next = addr_inc;
                pos_next  = addr_inc;
                rcnt_next = '0;
            end
            DP_RND_WR: begin
                mem_we    = 1'b1;
                mem_wdata = rnd_val;
                hold_next = rnd_val;
                addr_next = addr_inc;
                rcnt_next = rcnt_reg + ROUNDS_W'(1);
            end
            DP_CREDIT: begin
                est_next = credit_est;
            end
            DP_SEED_INIT: begin
                acc_next  = xs_mix(word_reg[31:0], word_reg[63:32]);
                addr_next = '0;
                pos_next  = '0;
                est_next  = '0;
            end
            DP_SEED_WR: begin
                mem_we    = 1'b1;
                mem_wdata = acc_reg;
                acc_next  = xs_mix(acc_reg, 32'd0);
                addr_next = addr_inc;
            end
            DP_RESP: begin
                res_word_next  = ext_ok_reg ? acc_reg : '0;
                res_valid_next = ext_ok_reg;
                res_est_next   = est_reg;
            end
            default: begin
            end
        endcase
        // register writes
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_ROUNDS: rounds_next = cfg_data[ROUNDS_W-1:0];
                CFG_CAP:    cap_next    = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pool memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pool_mem[addr_reg] <= mem_wdata;
        end
        rd_reg <= pool_mem[addr_reg];
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg   <= '0;
            pos_reg    <= '0;
            est_reg    <= '0;
            rounds_reg <= ROUNDS_RESET;
            cap_reg    <= CAP_RESET;
            rcnt_reg   <= '0;
            ext_ok_reg <= 1'b0;
        end else begin
            addr_reg   <= addr_next;
            pos_reg    <= pos_next;
            est_reg    <= est_next;
            rounds_reg <= rounds_next;
            cap_reg    <= cap_next;
            rcnt_reg   <= rcnt_next;
            ext_ok_reg <= ext_ok_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        hold_reg      <= hold_next;
        kind_reg      <= kind_next;
        word_reg      <= word_next;
        last_reg      <= last_next;
        bytes_reg     <= bytes_next;
        res_word_reg  <= res_word_next;
        res_valid_reg <= res_valid_next;
        res_est_reg   <= res_est_next;
    end

endmodule

// ===== hdl/xorshift_entropy_pool_top.sv =====
// xorshift_entropy_pool_top: pool of POOL_DEPTH 32-bit words mixed with xorshift.
// Input stream s_*: s_tuser selects the item kind (mix, credit, extract, seed),
// s_tdata carries the 64-bit word and the extract byte count, s_tlast marks the
// final mix word of a message. Every input word yields exactly one output word
// on m_*: the extracted random word, a valid flag in m_tuser and the entropy
// estimate after the item. The user must write registers (diffusion rounds, entropy
// cap) through cfg_* only while no item is in flight; the block itself does not
// enforce this, and cfg_ready is always high. A mix word with s_tlast is followed
// by the diffusion rounds; an extract makes three reads and one write on the single
// pool port; a seed writes one pool word per cycle. The result enters the output
// register as the block returns to ready. Reset clears position, estimate and
// registers to their defaults, then a clearing pass writes zero over the pool, one
// word a cycle, with s_tready held low. A stalled receiver holds the result in the
// output register; the next item is still taken and processed, and waits in its
// last state until the output register is free.
`timescale 1ns / 1ps

module xorshift_entropy_pool_top #(
    parameter int POOL_DEPTH = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [71:0]                   s_tdata,   // word[63:0], byte_count[66:64], zero pad
    input  logic [1:0]                    s_tuser,   // kind[1:0]
    input  logic                          s_tlast,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // random_word[31:0], entropy_estimate[44:32], pad
    output logic                          m_tuser,   // word_valid
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [xep_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xep_pkg::EST_W-1:0]     cfg_data
);
    import xep_pkg::*;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [31:0]      res_word;
    logic             res_valid;
    logic [EST_W-1:0] res_est;

    assign cfg_ready = 1'b1;

    xep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .stat    (stat),
        .cmd     (cmd)
    );

    xep_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_kind   (kind_t'(s_tuser)),
        .in_word   (s_tdata[63:0]),
        .in_last   (s_tlast),
        .in_bytes  (s_tdata[66:64]),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_word  (res_word),
        .res_valid (res_valid),
        .res_est   (res_est)
    );

    // result word packing
    assign m_tdata = {3'b000, res_est, res_word};
    assign m_tuser = res_valid;

`ifndef SYNTHESIS
    // the clearing pass keeps the input closed right after reset
    a_clear_after_reset: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input accepted during pool clearing pass");

    // one item at a time: no second word right behind an accepted one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // a new result appears only as the controller returns to idle
    a_result_on_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded outside the response step");
`endif

endmodule

// ===== test/tb_xorshift_entropy_pool_top.sv =====
// tb_xorshift_entropy_pool_top: self-checking bench for the xorshift entropy pool,
// bursty item stream against a stalling receiver, results checked in a scoreboard
// that keeps its own copy of the pool; depends on xep_pkg and xorshift_entropy_pool_top
`timescale 1ns / 1ps

module tb_xorshift_entropy_pool_top;
    import xep_pkg::*;

    localparam int POOL_DEPTH      = 128;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int END_WAIT        = 50;
    localparam int REPORT_LIMIT    = 40;

    typedef struct {
        bit [31:0]      rword;
        bit             valid;
        bit [EST_W-1:0] est;
    } pool_result_t;

    // shadow pool and estimate, plus the results still owed by the block
    class pool_scoreboard;
        bit [31:0]         shadow_pool [POOL_DEPTH];
        int unsigned       wr_pos;
        bit [EST_W-1:0]    estimate;
        bit [ROUNDS_W-1:0] rounds;
        bit [EST_W-1:0]    cap;
        pool_result_t      owed_results [$];
        int unsigned       mismatches;

        function new();
            foreach (shadow_pool[i]) shadow_pool[i] = '0;
            wr_pos     = 0;
            estimate   = '0;
            rounds     = ROUNDS_RESET;
            cap        = CAP_RESET;
            mismatches = 0;
        endfunction

        function bit [31:0] xs_fold(bit [31:0] a, bit [31:0] b);
            bit [31:0] x;
            x = a ^ b;
            x ^= x << 13;
            x ^= x >> 17;
            x ^= x << 5;
            return x;
        endfunction

        function void set_reg(cfg_idx_t idx, bit [EST_W-1:0] val);
            case (idx)
                CFG_ROUNDS: rounds = val[ROUNDS_W-1:0];
                CFG_CAP:    cap = val;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        // apply one accepted item to the shadow state and queue its result
        function void note_item(kind_t kind, bit [63:0] word, bit last, bit [2:0] nbytes);
            pool_result_t res;
            int unsigned  p, nx, pv, j, q, debit;
            bit [31:0]    o;
            bit [64:0]    sum;
            bit [63:0]    s;
            res.rword = '0;
            res.valid = 1'b0;
            p = wr_pos;
            case (kind)
                KIND_MIX: begin
                    shadow_pool[p] = xs_fold(shadow_pool[p], word[31:0]);
                    p = (p + 1) % POOL_DEPTH;
                    // neighbour diffusion after the last word of a message
                    if (last) begin
                        for (int i = 0; i < rounds; i++) begin
                            j = (p + i) % POOL_DEPTH;
                            q = (j + POOL_DEPTH - 1) % POOL_DEPTH;
                            shadow_pool[j] = xs_fold(shadow_pool[j], shadow_pool[q]);
                        end
                    end
                    wr_pos = p;
                end
                KIND_CREDIT: begin
                    sum = {52'b0, estimate} + {1'b0, word};
                    if (sum > cap) estimate = cap;
                    else estimate = sum[EST_W-1:0];
                end
                KIND_EXTRACT: begin
                    // zero bytes leaves everything as it is
                    if (nbytes != 0) begin
                        nx = (p + 1) % POOL_DEPTH;
                        pv = (p + POOL_DEPTH - 1) % POOL_DEPTH;
                        o = xs_fold(xs_fold(shadow_pool[p], shadow_pool[nx]), shadow_pool[pv]);
                        o ^= word[31:0];
                        wr_pos = nx;
                        shadow_pool[nx] = xs_fold(shadow_pool[nx], o);
                        debit = ((nbytes > MAX_BYTES) ? MAX_BYTES : nbytes) * 8;
                        estimate = (estimate > debit) ? EST_W'(estimate - debit) : '0;
                        res.rword = o;
                        res.valid = 1'b1;
                    end
                end
                default: begin
                    // seed chain walks the whole pool
                    s = word;
                    for (int i = 0; i < POOL_DEPTH; i++) begin
                        s = {32'b0, xs_fold(s[31:0], s[63:32])};
                        shadow_pool[i] = s[31:0];
                    end
                    wr_pos   = 0;
                    estimate = '0;
                end
            endcase
            res.est = estimate;
            owed_results.push_back(res);
        endfunction

        // compare one result word against the oldest owed result
        function void check_result(logic [47:0] tdata, logic tuser);
            pool_result_t want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result word with nothing owed, data %h flag %b",
                             $realtime, tdata, tuser);
                return;
            end
            want = owed_results.pop_front();
            if (tdata[31:0] !== want.rword) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: random_word expected %h actual %h",
                             $realtime, want.rword, tdata[31:0]);
            end
            if (tuser !== want.valid) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: word_valid expected %b actual %b",
                             $realtime, want.valid, tuser);
            end
            if (tdata[44:32] !== want.est) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: entropy_estimate expected %0d actual %0d",
                             $realtime, want.est, tdata[44:32]);
            end
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [EST_W-1:0]     cfg_data  = '0;

    pool_scoreboard sb = new();
    int unsigned    burst_left = 0;
    int unsigned    idle_cycles = 0;
    int unsigned    stall_clock = 0;
    int unsigned    stall_mode = 0;

    xorshift_entropy_pool_top #(.POOL_DEPTH(POOL_DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: check accepted words, stall on a mode that changes now and then
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        stall_clock = stall_clock + 1;
        if (stall_clock % 256 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (stall_clock % 40) >= 28;
        endcase
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
    end

    // one item, preceded by a random gap when the current burst is used up
    task automatic send_item(input kind_t kind, input bit [63:0] word, input bit last,
                             input bit [2:0] nbytes);
        int r;
        int gap;
        if (burst_left == 0) begin
            r = $urandom_range(0, 99);
            gap = (r < 30) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(10, 40);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, nbytes, word};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(kind, word, last, nbytes);
    endtask

    // hold the sender until every owed result is back and the block is ready
    task automatic settle_pool();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // register word; cfg_valid is lowered by the caller after the last write
    task automatic write_reg(input cfg_idx_t idx, input bit [EST_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic run_directed();
        send_item(KIND_EXTRACT, 64'h0, 1'b0, 3'd4);            // extract from a zero pool
        send_item(KIND_CREDIT, 64'h0, 1'b1, 3'd0);
        send_item(KIND_CREDIT, '1, 1'b0, 3'd7);                // huge credit saturates
        send_item(KIND_CREDIT, 64'd5, 1'b0, 3'd0);             // credit at the cap
        send_item(KIND_EXTRACT, '1, 1'b0, 3'd0);               // zero bytes, no change
        send_item(KIND_EXTRACT, '1, 1'b1, 3'd7);               // debit capped at four bytes
        send_item(KIND_EXTRACT, 64'h0, 1'b0, 3'd1);
        send_item(KIND_SEED, '1, 1'b0, 3'd7);
        send_item(KIND_MIX, 64'hFFFF_FFFF_0000_0000, 1'b0, 3'd0); // upper half ignored
        send_item(KIND_MIX, 64'h0000_0000_FFFF_FFFF, 1'b1, 3'd7);
        send_item(KIND_EXTRACT, 64'h0, 1'b0, 3'd5);
        send_item(KIND_SEED, 64'h0, 1'b1, 3'd0);               // all-zero seed
        send_item(KIND_MIX, 64'h0123_4567_89AB_CDEF, 1'b1, 3'd2);
        send_item(KIND_CREDIT, 64'd4096, 1'b0, 3'd0);
        send_item(KIND_EXTRACT, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0, 3'd2);
        send_item(KIND_CREDIT, 64'h8000_0000_0000_0000, 1'b1, 3'd0);
        send_item(KIND_EXTRACT, 64'h0, 1'b0, 3'd3);
        send_item(KIND_EXTRACT, 64'hFFFF_FFFF, 1'b0, 3'd6);
        send_item(KIND_MIX, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 3'd4);
        send_item(KIND_MIX, 64'h1, 1'b1, 3'd0);
        send_item(KIND_CREDIT, 64'd4095, 1'b0, 3'd0);
        send_item(KIND_EXTRACT, 64'h0, 1'b1, 3'd4);
    endtask

    task automatic random_item();
        int        r;
        int        rb;
        bit [63:0] w;
        bit [2:0]  nb;
        bit        lst;
        r   = $urandom_range(0, 99);
        rb  = $urandom_range(0, 9);
        w   = {$urandom, $urandom};
        lst = 1'($urandom_range(0, 1));
        nb  = (rb == 0) ? 3'd0 : (rb < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(5, 7));
        if (r < 42) begin
            send_item(KIND_MIX, w, ($urandom_range(0, 4) == 0), nb);
        end else if (r < 62) begin
            rb = $urandom_range(0, 9);
            if (rb < 6) w = 64'($urandom_range(0, 200));
            else if (rb < 8) w = 64'($urandom_range(0, 5000));
            send_item(KIND_CREDIT, w, lst, nb);
        end else if (r < 95) begin
            send_item(KIND_EXTRACT, w, lst, nb);
        end else begin
            send_item(KIND_SEED, w, lst, nb);
        end
    endtask

    // phases with different register settings, extremes first
    initial begin
        bit [ROUNDS_W-1:0] rounds_set [PHASES];
        bit [EST_W-1:0]    cap_set [PHASES];
        rounds_set = '{7'd16, 7'd64, 7'd3, 7'd0, 7'd0};
        cap_set    = '{13'd4096, 13'd4096, 13'd100, 13'd0, 13'd0};
        rounds_set[PHASES-1] = ROUNDS_W'($urandom_range(0, 64));
        cap_set[PHASES-1]    = EST_W'($urandom_range(0, 4096));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_pool();
            write_reg(CFG_ROUNDS, EST_W'(rounds_set[ph]));
            write_reg(CFG_CAP, cap_set[ph]);
            cfg_valid <= 1'b0;
            if (ph == 0) run_directed();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2) settle_pool();
                random_item();
            end
        end
        settle_pool();
        repeat (END_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/xep_pkg.sv
hdl/xep_ctrl.sv
hdl/xep_datapath.sv
hdl/xorshift_entropy_pool_top.sv
test/tb_xorshift_entropy_pool_top.sv
